FILE: src/etf_pkg.sv
package etf_pkg;

  // Fixed number formats
  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM   = 2048;
  localparam int ITER_BITS = 12;

  localparam int PIX_W      = 11;
  localparam int DIM_W      = 12;
  localparam int CNT_W      = ITER_BITS;
  localparam int GREY_W     = 8;
  localparam int SEED_W     = 32;
  localparam int SEED_FRAC  = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Derived datapath widths
  localparam int Z_W    = FRAC_BITS + 4;         // Q4.F value
  localparam int M_W    = FRAC_BITS + 1;         // magnitude below 2.0
  localparam int P_W    = 2 * M_W;               // full product
  localparam int QUO_W  = PIX_W + FRAC_BITS + 2; // coordinate quotient bits
  localparam int STEP_W = $clog2(QUO_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_REAL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_IMAG       = 3'd5;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH     = 12'd1024;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT    = 12'd1024;
  localparam logic [CNT_W-1:0]  RST_ITERATION_LIMIT = 12'd100;
  localparam logic              RST_JULIA_MODE      = 1'b0;
  localparam logic [SEED_W-1:0] RST_SEED            = 32'd0;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [CNT_W-1:0]  iteration_limit;
    logic              julia_mode;
    logic [SEED_W-1:0] seed_real;
    logic [SEED_W-1:0] seed_imag;
  } etf_cfg_t;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV,
    CMD_INIT,
    CMD_MUL,
    CMD_UPD,
    CMD_GREY_LOAD,
    CMD_GREY_STEP,
    CMD_OUT
  } etf_cmd_e;

  typedef struct packed {
    logic at_limit;
    logic escape;
  } etf_status_t;

endpackage

FILE: src/etf_cfg.sv
module etf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [etf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [etf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output etf_pkg::etf_cfg_t                cfg_o
);

  etf_pkg::etf_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode a config word into its register, drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        etf_pkg::REG_IMAGE_WIDTH:     cfg_d.image_width     = cfg_data_i[etf_pkg::DIM_W-1:0];
        etf_pkg::REG_IMAGE_HEIGHT:    cfg_d.image_height    = cfg_data_i[etf_pkg::DIM_W-1:0];
        etf_pkg::REG_ITERATION_LIMIT: cfg_d.iteration_limit = cfg_data_i[etf_pkg::CNT_W-1:0];
        etf_pkg::REG_JULIA_MODE:      cfg_d.julia_mode      = cfg_data_i[0];
        etf_pkg::REG_SEED_REAL:       cfg_d.seed_real       = cfg_data_i[etf_pkg::SEED_W-1:0];
        etf_pkg::REG_SEED_IMAG:       cfg_d.seed_imag       = cfg_data_i[etf_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width     <= etf_pkg::RST_IMAGE_WIDTH;
      cfg_q.image_height    <= etf_pkg::RST_IMAGE_HEIGHT;
      cfg_q.iteration_limit <= etf_pkg::RST_ITERATION_LIMIT;
      cfg_q.julia_mode      <= etf_pkg::RST_JULIA_MODE;
      cfg_q.seed_real       <= etf_pkg::RST_SEED;
      cfg_q.seed_imag       <= etf_pkg::RST_SEED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/etf_cdiv.sv
module etf_cdiv #(
  parameter int  MAX_DIM = etf_pkg::MAX_DIM,
  localparam int DIV_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [etf_pkg::PIX_W-1:0]   pos_i,
  input  logic [DIV_W-1:0]            div_i,
  output logic [etf_pkg::QUO_W-1:0]   quot_o
);

  localparam int QUO_W = etf_pkg::QUO_W;
  localparam int PIX_W = etf_pkg::PIX_W;

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] num_q, num_d;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   trial_sub;
  logic             fits;

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_q, num_q[QUO_W-1]};
    trial_sub = trial - {1'b0, div_i};
    fits      = (trial >= {1'b0, div_i});
    rem_d     = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
    num_d     = {num_q[QUO_W-2:0], fits};
  end

  // Load position scaled by 2^(F+2), then advance one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= {pos_i, {(QUO_W-PIX_W){1'b0}}};
    end else if (step_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign quot_o = num_q;

endmodule

FILE: src/etf_dp.sv
module etf_dp #(
  parameter int  MAX_DIM = etf_pkg::MAX_DIM
) (
  input  logic                         clk_i,
  input  etf_pkg::etf_cmd_e            cmd_i,
  input  etf_pkg::etf_cfg_t            cfg_i,
  input  logic [etf_pkg::PIX_W-1:0]    pixel_x_i,
  input  logic [etf_pkg::PIX_W-1:0]    pixel_y_i,
  output etf_pkg::etf_status_t         status_o,
  output logic [etf_pkg::GREY_W-1:0]   grey_level_o,
  output logic [etf_pkg::CNT_W-1:0]    iteration_count_o,
  output logic                         inside_set_o
);

  localparam int FRAC_BITS = etf_pkg::FRAC_BITS;
  localparam int Z_W       = etf_pkg::Z_W;
  localparam int M_W       = etf_pkg::M_W;
  localparam int P_W       = etf_pkg::P_W;
  localparam int QUO_W     = etf_pkg::QUO_W;
  localparam int CNT_W     = etf_pkg::CNT_W;
  localparam int GREY_W    = etf_pkg::GREY_W;
  localparam int DIM_W     = etf_pkg::DIM_W;
  localparam int SEED_W    = etf_pkg::SEED_W;
  localparam int DIV_W     = $clog2(MAX_DIM + 1);
  localparam int CMP_W     = DIM_W + 1;
  localparam int E_W       = Z_W + 2;
  localparam int SX_W      = (Z_W > SEED_W) ? Z_W : SEED_W;
  localparam int SH_L      = (FRAC_BITS >= etf_pkg::SEED_FRAC) ? FRAC_BITS - etf_pkg::SEED_FRAC : 0;
  localparam int SH_R      = (FRAC_BITS >= etf_pkg::SEED_FRAC) ? 0 : etf_pkg::SEED_FRAC - FRAC_BITS;
  localparam int R2_W      = P_W - FRAC_BITS;
  localparam int Q_W       = P_W - FRAC_BITS + 1;
  localparam int D_W       = CNT_W + GREY_W;

  localparam logic [Z_W-1:0] QMAX_Z = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [Z_W-1:0] QMIN_Z = {1'b1, {(Z_W-1){1'b0}}};
  localparam logic [QUO_W:0] TWO_Q  = (QUO_W+1)'(1) << (FRAC_BITS + 1);

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIV_W-1:0] eff_div(input logic [DIM_W-1:0] d);
    logic [DIV_W-1:0] r;
    if (d == '0) begin
      r = DIV_W'(1);
    end else if ({1'b0, d} > CMP_W'(MAX_DIM)) begin
      r = DIV_W'(MAX_DIM);
    end else begin
      r = DIV_W'(d);
    end
    return r;
  endfunction

  // Shift the quotient down by 2.0 and clip at the top of the Q4 range
  function automatic logic [Z_W-1:0] to_coord(input logic [QUO_W-1:0] quot);
    logic [QUO_W:0] diff;
    logic [Z_W-1:0] r;
    diff = {1'b0, quot} - TWO_Q;
    if ($signed(diff) > $signed((QUO_W+1)'(QMAX_Z))) begin
      r = QMAX_Z;
    end else begin
      r = diff[Z_W-1:0];
    end
    return r;
  endfunction

  // Saturate a widened sum to Q4
  function automatic logic [Z_W-1:0] sat_q(input logic signed [E_W-1:0] v);
    logic [Z_W-1:0] r;
    if (v > $signed({2'b00, QMAX_Z})) begin
      r = QMAX_Z;
    end else if (v < $signed({2'b11, QMIN_Z})) begin
      r = QMIN_Z;
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

  // Coordinate dividers
  logic             div_start;
  logic             div_step;
  logic [QUO_W-1:0] quot_x;
  logic [QUO_W-1:0] quot_y;

  assign div_start = (cmd_i == etf_pkg::CMD_LOAD);
  assign div_step  = (cmd_i == etf_pkg::CMD_DIV);

  etf_cdiv #(.MAX_DIM(MAX_DIM)) u_div_x (
    .clk_i   (clk_i),
    .start_i (div_start),
    .step_i  (div_step),
    .pos_i   (pixel_x_i),
    .div_i   (eff_div(cfg_i.image_width)),
    .quot_o  (quot_x)
  );

  etf_cdiv #(.MAX_DIM(MAX_DIM)) u_div_y (
    .clk_i   (clk_i),
    .start_i (div_start),
    .step_i  (div_step),
    .pos_i   (pixel_y_i),
    .div_i   (eff_div(cfg_i.image_height)),
    .quot_o  (quot_y)
  );

  // Iteration state
  logic [Z_W-1:0]    zr_q, zi_q, cr_q, ci_q;
  logic [CNT_W-1:0]  n_q;
  logic [P_W-1:0]    prr_q, pii_q, pri_q;
  logic              mag_esc_q;
  logic              neg_q;
  logic [CNT_W-1:0]  gr_rem_q;
  logic [GREY_W-1:0] gr_num_q;
  logic [GREY_W-1:0] grey_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              inside_q;

  // Pixel point and rescaled seed
  logic [Z_W-1:0]         pr, pi, sr, si;
  logic signed [SX_W-1:0] sr_ext, si_ext, sr_sh, si_sh;

  always_comb begin
    pr     = to_coord(quot_x);
    pi     = to_coord(quot_y);
    sr_ext = SX_W'($signed(cfg_i.seed_real));
    si_ext = SX_W'($signed(cfg_i.seed_imag));
    if (FRAC_BITS >= etf_pkg::SEED_FRAC) begin
      sr_sh = sr_ext <<< SH_L;
      si_sh = si_ext <<< SH_L;
    end else begin
      sr_sh = sr_ext >>> SH_R;
      si_sh = si_ext >>> SH_R;
    end
    sr = sr_sh[Z_W-1:0];
    si = si_sh[Z_W-1:0];
  end

  // Multiply stage: magnitudes, escape on a component of 2.0 or more, three products
  logic [Z_W-1:0] ar, ai;
  logic [M_W-1:0] arm, aim;
  logic [P_W-1:0] prr_d, pii_d, pri_d;
  logic           mag_esc_d;

  always_comb begin
    ar        = zr_q[Z_W-1] ? (-zr_q) : zr_q;
    ai        = zi_q[Z_W-1] ? (-zi_q) : zi_q;
    mag_esc_d = (|ar[Z_W-1:M_W]) | (|ai[Z_W-1:M_W]);
    arm       = ar[M_W-1:0];
    aim       = ai[M_W-1:0];
    prr_d     = arm * arm;
    pii_d     = aim * aim;
    pri_d     = arm * aim;
  end

  // Add stage: |z|^2 test and next z
  logic [R2_W-1:0]       re2, im2;
  logic [R2_W:0]         sq_sum;
  logic                  sum_esc;
  logic [Q_W-1:0]        cross_mag;
  logic                  sticky;
  logic [Z_W-1:0]        cross_abs;
  logic signed [E_W-1:0] cross_e, re_e, im_e;

  always_comb begin
    re2       = prr_q[P_W-1:FRAC_BITS];
    im2       = pii_q[P_W-1:FRAC_BITS];
    sq_sum    = {1'b0, re2} + {1'b0, im2};
    sum_esc   = sq_sum[FRAC_BITS+2];
    cross_mag = pri_q[P_W-1:FRAC_BITS-1];
    sticky    = |pri_q[FRAC_BITS-2:0];
    // A negative cross term rounds toward minus infinity
    cross_abs = Z_W'(cross_mag) + Z_W'(neg_q & sticky);
    cross_e   = neg_q ? -$signed({2'b00, cross_abs}) : $signed({2'b00, cross_abs});
    re_e      = $signed(E_W'(re2)) - $signed(E_W'(im2)) + $signed({{2{cr_q[Z_W-1]}}, cr_q});
    im_e      = cross_e + $signed({{2{ci_q[Z_W-1]}}, ci_q});
  end

  // Grey scaling: floor(n*255/limit) by restoring division, one bit per step
  logic [D_W-1:0]   prod255;
  logic [CNT_W:0]   g_trial;
  logic [CNT_W:0]   g_sub;
  logic             g_fits;

  always_comb begin
    prod255 = {n_q, {GREY_W{1'b0}}} - D_W'(n_q);
    g_trial = {gr_rem_q, gr_num_q[GREY_W-1]};
    g_sub   = g_trial - {1'b0, cfg_i.iteration_limit};
    g_fits  = (g_trial >= {1'b0, cfg_i.iteration_limit});
  end

  logic at_limit;
  assign at_limit = (n_q == cfg_i.iteration_limit);

  // Act on the controller command
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      etf_pkg::CMD_INIT: begin
        if (cfg_i.julia_mode) begin
          zr_q <= pr;
          zi_q <= pi;
          cr_q <= sr;
          ci_q <= si;
        end else begin
          zr_q <= sr;
          zi_q <= si;
          cr_q <= pr;
          ci_q <= pi;
        end
        n_q <= '0;
      end
      etf_pkg::CMD_MUL: begin
        prr_q     <= prr_d;
        pii_q     <= pii_d;
        pri_q     <= pri_d;
        mag_esc_q <= mag_esc_d;
        neg_q     <= zr_q[Z_W-1] ^ zi_q[Z_W-1];
      end
      etf_pkg::CMD_UPD: begin
        zr_q <= sat_q(re_e);
        zi_q <= sat_q(im_e);
        n_q  <= n_q + CNT_W'(1);
      end
      etf_pkg::CMD_GREY_LOAD: begin
        gr_rem_q <= prod255[D_W-1:GREY_W];
        gr_num_q <= prod255[GREY_W-1:0];
      end
      etf_pkg::CMD_GREY_STEP: begin
        gr_rem_q <= g_fits ? g_sub[CNT_W-1:0] : g_trial[CNT_W-1:0];
        gr_num_q <= {gr_num_q[GREY_W-2:0], g_fits};
      end
      etf_pkg::CMD_OUT: begin
        grey_q   <= at_limit ? '0 : gr_num_q;
        cnt_q    <= n_q;
        inside_q <= at_limit;
      end
      default: ;
    endcase
  end

  assign status_o.at_limit = at_limit;
  assign status_o.escape   = mag_esc_q | sum_esc;

  assign grey_level_o      = grey_q;
  assign iteration_count_o = cnt_q;
  assign inside_set_o      = inside_q;

endmodule

FILE: src/etf_ctrl.sv
module etf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  etf_pkg::etf_status_t  status_i,
  output etf_pkg::etf_cmd_e     cmd_o
);

  localparam int STEP_W = etf_pkg::STEP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_GREY = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  // Sequence one pixel: divide, iterate, scale an escaped count, hand to the output register
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = etf_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = etf_pkg::CMD_LOAD;
          step_d  = STEP_W'(etf_pkg::QUO_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o = etf_pkg::CMD_DIV;
        if (step_q == '0) begin
          state_d = S_INIT;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      S_INIT: begin
        cmd_o   = etf_pkg::CMD_INIT;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (status_i.at_limit) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = etf_pkg::CMD_MUL;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (status_i.escape) begin
          cmd_o   = etf_pkg::CMD_GREY_LOAD;
          step_d  = STEP_W'(etf_pkg::GREY_W - 1);
          state_d = S_GREY;
        end else begin
          cmd_o   = etf_pkg::CMD_UPD;
          state_d = S_MUL;
        end
      end
      S_GREY: begin
        cmd_o = etf_pkg::CMD_GREY_STEP;
        if (step_q == '0) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      S_FIN: begin
        // Hold until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o    = etf_pkg::CMD_OUT;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word is held until taken
  assign out_valid_d = (out_valid_q & ~out_ready_i) | out_load;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/escape_time_fractal_pixel_core.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pixel_x, pixel_y
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: grey_level, iteration_count;
//                                              tuser: inside_set
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One pixel at a time. Each accepted pixel goes through bit-serial coordinate division,
// then iterations, each a multiply step on three parallel multipliers followed by the
// add and |z|^2 compare, then, for a pixel that escapes, a bit-serial grey scaling
// division; a pixel that reaches the limit goes straight to the output register.
// The output register holds a result while the next pixel is accepted and computed.
// Reset restores the configuration to its defaults and empties the output register.
module escape_time_fractal_pixel_core #(
  parameter int MAX_DIM = etf_pkg::MAX_DIM
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [etf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // pixel_x[10:0], pixel_y[21:11]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [etf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // grey_level[7:0], iteration_count[19:8]
  output logic                               m_axis_tuser,  // inside_set[0]
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [etf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [etf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int PIX_W  = etf_pkg::PIX_W;
  localparam int GREY_W = etf_pkg::GREY_W;
  localparam int CNT_W  = etf_pkg::CNT_W;

  etf_pkg::etf_cfg_t    cfg;
  etf_pkg::etf_cmd_e    cmd;
  etf_pkg::etf_status_t status;
  logic [GREY_W-1:0]    grey_level;
  logic [CNT_W-1:0]     iteration_count;
  logic                 inside_set;

  etf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  etf_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .pixel_x_i         (s_axis_tdata[PIX_W-1:0]),
    .pixel_y_i         (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .status_o          (status),
    .grey_level_o      (grey_level),
    .iteration_count_o (iteration_count),
    .inside_set_o      (inside_set)
  );

  // Pack the result word
  assign m_axis_tdata = {{(etf_pkg::OUT_DATA_W-GREY_W-CNT_W){1'b0}}, iteration_count, grey_level};
  assign m_axis_tuser = inside_set;

endmodule
